[rtl/htd_pkg.sv]
// package for the huffman tree decoder
// shared widths, item mode codes and register indexes; no dependencies
package htd_pkg;

  localparam int IDX_BITS   = 9;
  localparam int BYTE_BITS  = 8;
  localparam int CNT_BITS   = 4;
  localparam int PAD_BITS   = 3;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam int REG_BITS   = 1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  localparam logic [REG_BITS-1:0] REG_ROOT = 1'b0;

endpackage

[rtl/htd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module htd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/htd_seq.sv]
// bit walk sequencer of the huffman tree decoder: node table reads, symbol
// hold and output register; depends on htd_pkg and drives one htd_ram
module htd_seq #(
  parameter int MAX_NODES   = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [htd_pkg::IDX_BITS-1:0]       root,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [htd_pkg::IDX_BITS-1:0]       node_index,
  input  logic [htd_pkg::IDX_BITS-1:0]       left_child,
  input  logic [htd_pkg::IDX_BITS-1:0]       right_child,
  input  logic                               is_leaf,
  input  logic [SYMBOL_BITS-1:0]             leaf_symbol,
  input  logic [htd_pkg::BYTE_BITS-1:0]      packed_byte,
  input  logic                               final_byte,
  input  logic [htd_pkg::PAD_BITS-1:0]       pad_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [SYMBOL_BITS-1:0]             symbol,
  output logic                               last_of_run,
  output logic                               mem_we,
  output logic [$clog2(MAX_NODES)-1:0]       mem_waddr,
  output logic [2*htd_pkg::IDX_BITS+SYMBOL_BITS:0] mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(MAX_NODES)-1:0]       mem_raddr,
  input  logic [2*htd_pkg::IDX_BITS+SYMBOL_BITS:0] mem_rdata
);
  import htd_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  typedef struct packed {
    logic [IDX_BITS-1:0]    left;
    logic [IDX_BITS-1:0]    right;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CUR,
    S_CHILD,
    S_FIN
  } state_t;

  state_t                 state;
  logic [IDX_BITS-1:0]    walk;
  logic [BYTE_BITS-1:0]   shreg;
  logic [CNT_BITS-1:0]    bits_left;
  logic                   fin;
  logic                   rd_ok;
  logic [IDX_BITS-1:0]    rd_idx_q;
  logic                   pend_valid;
  logic [SYMBOL_BITS-1:0] pend_sym;

  node_t               cur;
  node_t               wr_node;
  logic [IDX_BITS-1:0] child;
  logic [IDX_BITS-1:0] rd_idx;
  logic                rd_req;
  logic                out_free;
  logic                stall;
  logic                emit;
  logic                emit_last;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cur      = rd_ok ? node_t'(mem_rdata) : '0;
  assign child    = shreg[BYTE_BITS-1] ? cur.right : cur.left;
  assign stall    = cur.leaf && pend_valid && !out_free;

  // node load
  assign wr_node.left  = left_child;
  assign wr_node.right = right_child;
  assign wr_node.leaf  = is_leaf;
  assign wr_node.sym   = leaf_symbol;
  assign mem_we    = in_valid && in_ready && (mode == MODE_LOAD) &&
                     (32'(node_index) < MAX_NODES);
  assign mem_waddr = AW'(node_index);
  assign mem_wdata = wr_node;

  always_comb begin
    rd_req = 1'b0;
    rd_idx = walk;
    case (state)
      S_IDLE: begin
        rd_req = in_valid && (mode == MODE_DATA);
      end
      S_CUR: begin
        rd_req = (bits_left != '0) && !cur.leaf;
        rd_idx = child;
      end
      S_CHILD: begin
        rd_req = !stall && (cur.leaf || (bits_left != '0));
        rd_idx = cur.leaf ? root : child;
      end
      default: begin
        rd_req = 1'b0;
      end
    endcase
  end

  // pending symbol moves to the output register
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    if ((state == S_CHILD) && !stall && cur.leaf && pend_valid) begin
      emit = 1'b1;
    end
    if ((state == S_FIN) && pend_valid && out_free) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end
  end

  assign mem_re    = rd_req;
  assign mem_raddr = AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_ok      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid   <= 1'b1;
        symbol      <= pend_sym;
        last_of_run <= emit_last;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (rd_req) begin
        rd_ok    <= (32'(rd_idx) < MAX_NODES);
        rd_idx_q <= rd_idx;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && (mode == MODE_DATA)) begin
            shreg     <= packed_byte;
            bits_left <= final_byte ? CNT_BITS'(BYTE_BITS) - CNT_BITS'(pad_bits)
                                    : CNT_BITS'(BYTE_BITS);
            fin       <= final_byte;
            state     <= S_CUR;
          end
        end
        S_CUR: begin
          if ((bits_left == '0) || cur.leaf) begin
            state <= S_FIN;
          end else begin
            shreg     <= shreg << 1;
            bits_left <= bits_left - 1'b1;
            state     <= S_CHILD;
          end
        end
        S_CHILD: begin
          if (!stall) begin
            if (cur.leaf) begin
              walk       <= root;
              pend_valid <= 1'b1;
              pend_sym   <= cur.sym;
              state      <= S_CUR;
            end else begin
              walk <= rd_idx_q;
              if (bits_left == '0) begin
                state <= S_FIN;
              end else begin
                shreg     <= shreg << 1;
                bits_left <= bits_left - 1'b1;
              end
            end
          end
        end
        S_FIN: begin
          if (!pend_valid || out_free) begin
            if (fin) begin
              walk <= root;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/huffman_tree_decoder_unit.sv]
// Huffman decoder over a node table loaded through the input channel. A load
// transaction (mode 0) writes one node. A data transaction (mode 1) walks the
// tree one code bit per cycle, MSB first, while the output is not held: every
// bit is one dependent read of the node table RAM, whose registered read sets
// the pace. The code bits used per byte are 8, or 8 minus the padding on the
// final byte, and each symbol found costs one extra reread of the root node; a
// held output stalls the walk. The table needs no clearing pass after reset.
// The root index sits in an APB register at byte address 0. top level: depends
// on htd_pkg, htd_seq and htd_ram
module huffman_tree_decoder_unit #(
  parameter int MAX_NODES   = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [htd_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [htd_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [htd_pkg::PDATA_BITS-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [htd_pkg::IDX_BITS-1:0]      node_index,
  input  logic [htd_pkg::IDX_BITS-1:0]      left_child,
  input  logic [htd_pkg::IDX_BITS-1:0]      right_child,
  input  logic                              is_leaf,
  input  logic [SYMBOL_BITS-1:0]            leaf_symbol,
  input  logic [htd_pkg::BYTE_BITS-1:0]     packed_byte,
  input  logic                              final_byte,
  input  logic [htd_pkg::PAD_BITS-1:0]      pad_bits,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SYMBOL_BITS-1:0]            symbol,
  output logic                              last_of_run
);
  import htd_pkg::*;

  localparam int AW     = $clog2(MAX_NODES);
  localparam int NODE_W = 2 * IDX_BITS + 1 + SYMBOL_BITS;

  logic [IDX_BITS-1:0] root;
  logic [REG_BITS-1:0] reg_sel;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [NODE_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [NODE_W-1:0]   mem_rdata;

  // register index from the word address
  assign reg_sel = paddr[PADDR_BITS-1 -: REG_BITS];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_ROOT) ? PDATA_BITS'(root) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_ROOT)) begin
      root <= pwdata[IDX_BITS-1:0];
    end
  end

  htd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  htd_seq #(
    .MAX_NODES   (MAX_NODES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .root        (root),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .node_index  (node_index),
    .left_child  (left_child),
    .right_child (right_child),
    .is_leaf     (is_leaf),
    .leaf_symbol (leaf_symbol),
    .packed_byte (packed_byte),
    .final_byte  (final_byte),
    .pad_bits    (pad_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last_of_run (last_of_run),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

[rtl/htd_checker.sv]
// port level checks for the huffman tree decoder, bound to the top level
// depends on htd_pkg
module htd_checker #(
  parameter int SYMBOL_BITS = 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           pready,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           mode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [SYMBOL_BITS-1:0]         symbol,
  input logic                           last_of_run
);
  import htd_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last_of_run))
    else $error("result changed while stalled");

  // a node load leaves the block ready for the next transaction
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_LOAD) |=> in_ready)
    else $error("not ready after node load");

  // a data byte keeps the block busy while the walk runs
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_DATA) |=> !in_ready ##1 !in_ready)
    else $error("ready during data byte walk");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind huffman_tree_decoder_unit htd_checker #(
  .SYMBOL_BITS (SYMBOL_BITS)
) u_htd_checker (
  .clk         (clk),
  .rst         (rst),
  .pready      (pready),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .mode        (mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .symbol      (symbol),
  .last_of_run (last_of_run)
);

[dv/huffman_tree_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for huffman_tree_decoder_unit: loads node tables,
// decodes packed bytes and checks each symbol against an in-bench tree walk or typed list
// depends on htd_pkg and the decoder rtl only
module huffman_tree_decoder_unit_tb;
  import htd_pkg::*;

  localparam int SYM_W         = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int TOTAL_ITEMS   = 280;
  localparam int LIMIT_NS      = 2_000_000;
  localparam int REG_SPARE     = 1;
  localparam logic [PADDR_BITS-1:0] ADDR_ROOT  = PADDR_BITS'(4 * REG_ROOT);
  localparam logic [PADDR_BITS-1:0] ADDR_SPARE = PADDR_BITS'(4 * REG_SPARE);

  typedef struct {
    logic                 mode;
    logic [IDX_BITS-1:0]  node_index;
    logic [IDX_BITS-1:0]  left_child;
    logic [IDX_BITS-1:0]  right_child;
    logic                 is_leaf;
    logic [SYM_W-1:0]     leaf_symbol;
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 final_byte;
    logic [PAD_BITS-1:0]  pad_bits;
  } item_t;

  typedef struct {
    logic [IDX_BITS-1:0] left;
    logic [IDX_BITS-1:0] right;
    logic                leaf;
    logic [SYM_W-1:0]    sym;
  } tree_node_t;

  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             last;
  } symbol_t;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [PADDR_BITS-1:0] addr;
    logic [31:0]           wdata;
    item_t                 item;
    int                    want_n;
    logic [63:0]           want_syms;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode = MODE_LOAD;
  logic [IDX_BITS-1:0]   node_index = '0;
  logic [IDX_BITS-1:0]   left_child = '0;
  logic [IDX_BITS-1:0]   right_child = '0;
  logic                  is_leaf = 1'b0;
  logic [SYM_W-1:0]      leaf_symbol = '0;
  logic [BYTE_BITS-1:0]  packed_byte = '0;
  logic                  final_byte = 1'b0;
  logic [PAD_BITS-1:0]   pad_bits = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      symbol;
  logic                  last_of_run;

  // decoder state as seen from outside
  tree_node_t          node_mem [512];
  bit                  node_loaded [512];
  logic [IDX_BITS-1:0] walk_at = '0;
  logic [IDX_BITS-1:0] root_reg = '0;
  symbol_t             awaited_symbols [$];
  symbol_t             step_syms [8];
  symbol_t             rx_want;
  bit                  in_tree [512];

  int fails = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int root_writes = 0;
  int symbols_seen = 0;
  int ready_pause = 0;
  int rx_cycle = 0;
  bit held_long = 1'b0;
  bit tx_quiet = 1'b0;

  always #2 clk = ~clk;

  huffman_tree_decoder_unit uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .node_index  (node_index),
    .left_child  (left_child),
    .right_child (right_child),
    .is_leaf     (is_leaf),
    .leaf_symbol (leaf_symbol),
    .packed_byte (packed_byte),
    .final_byte  (final_byte),
    .pad_bits    (pad_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last_of_run (last_of_run)
  );

  // records a node load or steps the tree walk for one accepted transaction, fills step_syms
  function automatic int walk_tree(input item_t it);
    tree_node_t          here;
    logic [IDX_BITS-1:0] nxt;
    int                  nbits;
    int                  n = 0;
    if (it.mode == MODE_LOAD) begin
      node_mem[it.node_index] = '{it.left_child, it.right_child, it.is_leaf, it.leaf_symbol};
      node_loaded[it.node_index] = 1'b1;
      return 0;
    end
    nbits = it.final_byte ? BYTE_BITS - int'(it.pad_bits) : BYTE_BITS;
    for (int i = 0; i < nbits; i++) begin
      here = node_mem[walk_at];
      if (here.leaf === 1'b1) continue;
      nxt = it.packed_byte[BYTE_BITS-1-i] ? here.right : here.left;
      if (!node_loaded[walk_at] || !node_loaded[nxt]) begin
        $error("walk touched a node that was never loaded (at %0d)", walk_at);
        fails++;
      end
      if (node_mem[nxt].leaf === 1'b1) begin
        step_syms[n] = '{node_mem[nxt].sym, 1'b0};
        n++;
        walk_at = root_reg;
      end else begin
        walk_at = nxt;
      end
    end
    if (n > 0) step_syms[n-1].last = 1'b1;
    if (it.final_byte) walk_at = root_reg;
    return n;
  endfunction

  function automatic item_t load_item(input logic [IDX_BITS-1:0] idx, l, r,
                                      input logic leaf, input logic [SYM_W-1:0] sym);
    item_t it;
    it.mode        = MODE_LOAD;
    it.node_index  = idx;
    it.left_child  = l;
    it.right_child = r;
    it.is_leaf     = leaf;
    it.leaf_symbol = sym;
    it.packed_byte = BYTE_BITS'($urandom);
    it.final_byte  = 1'($urandom);
    it.pad_bits    = PAD_BITS'($urandom);
    return it;
  endfunction

  function automatic item_t data_item(input logic [BYTE_BITS-1:0] byte_in, input logic fin,
                                      input logic [PAD_BITS-1:0] pad);
    item_t it;
    it.mode        = MODE_DATA;
    it.node_index  = IDX_BITS'($urandom);
    it.left_child  = IDX_BITS'($urandom);
    it.right_child = IDX_BITS'($urandom);
    it.is_leaf     = 1'($urandom);
    it.leaf_symbol = SYM_W'($urandom);
    it.packed_byte = byte_in;
    it.final_byte  = fin;
    it.pad_bits    = pad;
    return it;
  endfunction

  function automatic dir_row_t item_row(input item_t it, input int n, input logic [63:0] syms);
    dir_row_t row;
    row.kind      = ROW_ITEM;
    row.addr      = '0;
    row.wdata     = '0;
    row.item      = it;
    row.want_n    = n;
    row.want_syms = syms;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [PADDR_BITS-1:0] addr,
                                       input logic [31:0] data);
    dir_row_t row;
    row       = item_row(data_item('0, 1'b0, '0), 0, '0);
    row.kind  = ROW_REG;
    row.addr  = addr;
    row.wdata = data;
    return row;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [IDX_BITS-1:0] claim_index();
    logic [IDX_BITS-1:0] id;
    do id = IDX_BITS'($urandom); while (in_tree[id]);
    in_tree[id] = 1'b1;
    return id;
  endfunction

  // want_n < 0 takes the walk's prediction, else the typed symbols
  task automatic send_item(input item_t it, input int want_n, input logic [63:0] want_syms);
    int gap;
    int n;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode        <= it.mode;
    node_index  <= it.node_index;
    left_child  <= it.left_child;
    right_child <= it.right_child;
    is_leaf     <= it.is_leaf;
    leaf_symbol <= it.leaf_symbol;
    packed_byte <= it.packed_byte;
    final_byte  <= it.final_byte;
    pad_bits    <= it.pad_bits;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = walk_tree(it);
    if (want_n >= 0) begin
      for (int i = 0; i < want_n; i++)
        awaited_symbols.push_back('{want_syms[63-8*i -: 8], 1'(i == want_n - 1)});
    end else begin
      for (int i = 0; i < n; i++) awaited_symbols.push_back(step_syms[i]);
    end
    items_sent++;
    if (it.mode == MODE_LOAD) loads_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_ROOT) begin
      root_reg = data[IDX_BITS-1:0];
      root_writes++;
      // read back in the following transaction
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata !== PDATA_BITS'(root_reg)) begin
        $error("prdata: expected %0h, got %0h", PDATA_BITS'(root_reg), prdata);
        fails++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stray loads outside the current tree and stray data bytes
  task automatic maybe_noise();
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] l;
    logic [IDX_BITS-1:0] r;
    if ($urandom_range(0, 4) != 0) return;
    if ($urandom_range(0, 1) == 0) begin
      send_item(data_item(BYTE_BITS'($urandom), 1'($urandom), PAD_BITS'($urandom)), -1, '0);
      return;
    end
    do idx = IDX_BITS'($urandom); while (in_tree[idx]);
    do l = IDX_BITS'($urandom); while (!node_loaded[l]);
    do r = IDX_BITS'($urandom); while (!node_loaded[r]);
    send_item(load_item(idx, l, r, 1'($urandom), SYM_W'($urandom)), -1, '0);
  endtask

  // builds a random tree bottom up, points the root at it, then decodes
  task automatic run_episode(input int ep);
    logic [IDX_BITS-1:0] roots [$];
    logic [IDX_BITS-1:0] a;
    logic [IDX_BITS-1:0] b;
    logic [IDX_BITS-1:0] id;
    int k;
    int pos;
    int m;
    tx_quiet = ($urandom_range(0, 3) == 0);
    foreach (in_tree[i]) in_tree[i] = 1'b0;
    if (ep == 0) in_tree[511] = 1'b1;
    k = (ep % 5 == 4) ? 1 : $urandom_range(2, 9);
    for (int i = 0; i < k; i++) begin
      id = claim_index();
      maybe_noise();
      send_item(load_item(id, IDX_BITS'($urandom), IDX_BITS'($urandom), 1'b1,
                          SYM_W'($urandom)), -1, '0);
      roots.push_back(id);
    end
    while (roots.size() > 1) begin
      pos = $urandom_range(0, roots.size() - 1);
      a = roots[pos];
      roots.delete(pos);
      pos = $urandom_range(0, roots.size() - 1);
      b = roots[pos];
      roots.delete(pos);
      id = (ep == 0 && roots.size() == 0) ? IDX_BITS'(511) : claim_index();
      maybe_noise();
      send_item(load_item(id, a, b, 1'b0, SYM_W'($urandom)), -1, '0);
      roots.push_back(id);
    end
    write_reg(ADDR_ROOT, 32'(roots[0]));
    if ($urandom_range(0, 3) == 0) write_reg(ADDR_SPARE, $urandom);
    m = $urandom_range(1, 6);
    for (int j = 0; j < m; j++) begin
      maybe_noise();
      send_item(data_item(BYTE_BITS'($urandom), 1'(j == m - 1 && $urandom_range(0, 4) != 0),
                          PAD_BITS'($urandom)), -1, '0);
    end
  endtask

  // output side: checks each transaction, stalls at random, one long hold
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      symbols_seen++;
      if (awaited_symbols.size() == 0) begin
        $error("symbol %0h arrived with nothing awaited", symbol);
        fails++;
      end else begin
        rx_want = awaited_symbols.pop_front();
        if (symbol !== rx_want.sym) begin
          $error("symbol: expected %0h, got %0h", rx_want.sym, symbol);
          fails++;
        end
        if (last_of_run !== rx_want.last) begin
          $error("last_of_run: expected %0b, got %0b", rx_want.last, last_of_run);
          fails++;
        end
      end
    end
    rx_cycle++;
    if (ready_pause > 0) begin
      ready_pause--;
      out_ready <= 1'b0;
    end else if (!held_long && symbols_seen >= 60) begin
      held_long = 1'b1;
      ready_pause = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ((rx_cycle / 700) % 3 != 2 && $urandom_range(0, 3) == 0)
        ready_pause = pick_gap(1'b0);
    end
  end

  initial begin : stimulus
    dir_row_t rows [$];
    int ep;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // two-leaf tree at node 0: every bit is one symbol
    rows.push_back(item_row(load_item(9'd0, 9'd1, 9'd511, 1'b0, 8'h5A), 0, '0));
    rows.push_back(item_row(load_item(9'd1, 9'h1FF, 9'h000, 1'b1, 8'h00), 0, '0));
    rows.push_back(item_row(load_item(9'd511, 9'h1FF, 9'h1FF, 1'b1, 8'hFF), 0, '0));
    // padding ignored on a non-final byte, applied on a final one
    rows.push_back(item_row(data_item(8'hA5, 1'b0, 3'd7), 8, 64'hFF00_FF00_00FF_00FF));
    rows.push_back(item_row(data_item(8'h00, 1'b1, 3'd0), 8, 64'h0));
    rows.push_back(item_row(data_item(8'hFF, 1'b1, 3'd7), 1, 64'hFF00_0000_0000_0000));
    rows.push_back(item_row(data_item(8'h5A, 1'b1, 3'd3), 5, 64'h00FF_00FF_FF00_0000));
    // deeper tree at 300
    rows.push_back(item_row(load_item(9'd300, 9'd301, 9'd302, 1'b0, 8'h00), 0, '0));
    rows.push_back(item_row(load_item(9'd301, 9'd303, 9'd304, 1'b0, 8'hFF), 0, '0));
    rows.push_back(item_row(load_item(9'd302, 9'd0, 9'd511, 1'b1, 8'h33), 0, '0));
    rows.push_back(item_row(load_item(9'd303, 9'd0, 9'd0, 1'b1, 8'h11), 0, '0));
    rows.push_back(item_row(load_item(9'd304, 9'd511, 9'd511, 1'b1, 8'h22), 0, '0));
    // new root takes effect only after the next leaf
    rows.push_back(reg_row(ADDR_ROOT, 32'd300));
    rows.push_back(item_row(data_item(8'h80, 1'b0, 3'd5), -1, '0));
    // root moved while the walk is mid-code
    rows.push_back(reg_row(ADDR_ROOT, 32'd0));
    rows.push_back(item_row(data_item(8'h40, 1'b0, 3'd2), -1, '0));
    rows.push_back(reg_row(ADDR_SPARE, 32'hFFFF_FFFF));
    rows.push_back(item_row(data_item(8'h00, 1'b1, 3'd7), 1, 64'h0));
    // root on a leaf: bits consumed with no output
    rows.push_back(reg_row(ADDR_ROOT, 32'd302));
    rows.push_back(item_row(data_item(8'h00, 1'b1, 3'd0), -1, '0));
    rows.push_back(item_row(data_item(8'hFF, 1'b0, 3'd0), 0, '0));
    rows.push_back(item_row(data_item(8'h3C, 1'b1, 3'd2), 0, '0));
    rows.push_back(reg_row(ADDR_ROOT, 32'd300));
    rows.push_back(item_row(data_item(8'hC3, 1'b1, 3'd0), 0, '0));
    rows.push_back(item_row(data_item(8'h37, 1'b1, 3'd1), -1, '0));
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) write_reg(rows[i].addr, rows[i].wdata);
      else send_item(rows[i].item, rows[i].want_n, rows[i].want_syms);
    end
    ep = 0;
    while (items_sent < TOTAL_ITEMS) begin
      run_episode(ep);
      ep++;
    end
    wait_idle();
    $display("covered %0d input transactions (%0d node loads) over %0d random trees",
             items_sent, loads_sent, ep);
    $display("%0d root settings, %0d symbols decoded, long output hold %0s",
             root_writes, symbols_seen, held_long ? "done" : "not reached");
    if (fails == 0) begin
      $display("huffman_tree_decoder_unit_tb OK");
    end else begin
      $display("huffman_tree_decoder_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("huffman_tree_decoder_unit_tb NOT OK");
    $finish;
  end

endmodule
